// File: rtl/core/ostp_pkg.sv
// Shared constants, types and the rounding multiply for the order statistic
// tail probability unit. No dependencies.
package ostp_pkg;

  localparam int MAX_DISTS = 8;
  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = MAX_DISTS + 1;

  localparam int P_W      = FRAC_BITS + 1;    // Q1.16 probability
  localparam int CNT_W    = FRAC_BITS + 2;    // count entry, headroom for rounding
  localparam int PROD_W   = CNT_W + P_W;
  localparam int SUM_W    = CNT_W + $clog2(NUM_LANES);
  localparam int LANE_W   = $clog2(NUM_LANES);
  localparam int LO_LANES = (NUM_LANES + 1) / 2;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [P_W-1:0]    ONE_FX  = P_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF_FX = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [CFG_W-1:0]  MAX_N   = CFG_W'(MAX_DISTS);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DISTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANK_K    = CFG_IDX_W'(1);

  typedef logic [NUM_LANES-1:0][CNT_W-1:0] cnt_vec_t;
  typedef logic [MAX_DISTS-1:0][P_W-1:0]   prob_vec_t;

  typedef struct packed {
    cnt_vec_t         cnt;
    prob_vec_t        prob;   // prob[0] is the one the next stage consumes
    logic [CFG_W-1:0] rank;
    logic             err;
  } stage_data_t;

  // round(a*b) to nearest, ties up, in Q.FRAC_BITS
  function automatic logic [CNT_W-1:0] mul_round(input logic [CNT_W-1:0] a,
                                                 input logic [P_W-1:0]   b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b) + HALF_FX;
    return prod[FRAC_BITS +: CNT_W];
  endfunction

endpackage

// File: rtl/core/ostp_lane.sv
// One count lane: new[c] = round(old[c]*q) + round(old[c-1]*p).
// Depends on ostp_pkg.
module ostp_lane (
  input  logic [ostp_pkg::CNT_W-1:0] cnt_self_i,
  input  logic [ostp_pkg::CNT_W-1:0] cnt_below_i,
  input  logic [ostp_pkg::P_W-1:0]   p_i,
  input  logic [ostp_pkg::P_W-1:0]   q_i,
  output logic [ostp_pkg::CNT_W-1:0] cnt_o
);
  import ostp_pkg::*;

  logic [CNT_W-1:0] stay, move;

  assign stay  = mul_round(cnt_self_i, q_i);
  assign move  = mul_round(cnt_below_i, p_i);
  assign cnt_o = CNT_W'(stay + move);

endmodule

// File: rtl/core/ostp_stage.sv
// One distribution step of the count recurrence: a row of lanes plus a
// pipeline register with valid/ready. Depends on ostp_pkg, ostp_lane.
module ostp_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ostp_pkg::stage_data_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ostp_pkg::stage_data_t out_data_o
);
  import ostp_pkg::*;

  logic             valid_q;
  stage_data_t      data_q, data_d;
  logic [P_W-1:0]   p, q;
  cnt_vec_t         cnt_new;

  // p == 0 for unused distributions makes the step an exact identity
  assign p = in_data_i.prob[0];
  assign q = ONE_FX - p;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c == 0) begin : g_bottom
      ostp_lane u_lane (
        .cnt_self_i  (in_data_i.cnt[c]),
        .cnt_below_i ('0),
        .p_i         (p),
        .q_i         (q),
        .cnt_o       (cnt_new[c])
      );
    end else begin : g_upper
      ostp_lane u_lane (
        .cnt_self_i  (in_data_i.cnt[c]),
        .cnt_below_i (in_data_i.cnt[c-1]),
        .p_i         (p),
        .q_i         (q),
        .cnt_o       (cnt_new[c])
      );
    end
  end

  always_comb begin
    data_d      = in_data_i;
    data_d.cnt  = cnt_new;
    data_d.prob = prob_vec_t'(in_data_i.prob >> P_W);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: rtl/core/ostp_merge.sv
// Tail merge: sums the count lanes at or above the rank over two
// registered steps, saturates at 1.0, gives 0 on a configuration error. Depends on ostp_pkg.
module ostp_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ostp_pkg::stage_data_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ostp_pkg::P_W-1:0] tail_prob_o,
  output logic                  config_error_o
);
  import ostp_pkg::*;

  logic             valid_a_q, valid_b_q;
  logic             ready_a, ready_b;
  logic [SUM_W-1:0] lo_d, hi_d, lo_q, hi_q, total;
  logic             err_a_q, err_b_q;
  logic [P_W-1:0]   tail_d, tail_q;

  // partial sums over the lower and upper halves of the lanes
  always_comb begin
    lo_d = '0;
    hi_d = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      if (LANE_W'(c) >= in_data_i.rank) begin
        if (c < LO_LANES) lo_d = lo_d + SUM_W'(in_data_i.cnt[c]);
        else              hi_d = hi_d + SUM_W'(in_data_i.cnt[c]);
      end
    end
  end

  assign total = lo_q + hi_q;

  always_comb begin
    if (err_a_q) begin
      tail_d = '0;
    end else if (total > SUM_W'(ONE_FX)) begin
      tail_d = ONE_FX;
    end else begin
      tail_d = total[P_W-1:0];
    end
  end

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) valid_a_q <= in_valid_i;
      if (ready_b) valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      err_a_q <= in_data_i.err;
    end
    if (ready_b && valid_a_q) begin
      tail_q  <= tail_d;
      err_b_q <= err_a_q;
    end
  end

  assign out_valid_o    = valid_b_q;
  assign tail_prob_o    = tail_q;
  assign config_error_o = err_b_q;

endmodule

// File: rtl/core/order_statistic_tail_prob_unit.sv
// Top level of the order statistic tail probability unit.
// Depends on ostp_pkg, ostp_stage, ostp_merge.
//
// Takes the CDF values (Q1.16, 65536 = 1.0) of up to eight independent
// distributions at one grid point and returns the chance that at least
// rank_k of them lie below it, in Q1.16 saturated at 1.0. The count
// distribution is built by one pipeline stage per distribution; each stage
// is a row of nine lanes, one per count value, each lane holding two
// 18x17 rounding multipliers and an adder. A two-step merge then sums the
// lanes at or above rank_k. The block takes one item per clock while the
// output is not held off; each item passes 8 recurrence stages and then
// 2 merge stages. Every stage has its own valid/ready, so bubbles collapse
// and new items keep entering, until every stage is full, while a
// finished result waits at the output. Inputs above 1.0 are
// clamped, distributions beyond num_dists are fed as zero (an exact
// identity step), num_dists above 8 counts as 8. When rank_k is 0 or
// exceeds the distribution count, config_error is set and tail_prob is 0.
// Register 0 is num_dists, register 1 is rank_k; other indexes are
// ignored. Both reset to 1 and are to be written only while no item is in
// flight. There is no clearing pass after reset.
module order_statistic_tail_prob_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ostp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ostp_pkg::CFG_W-1:0]    cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ostp_pkg::P_W-1:0]      prob_0_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_1_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_2_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_3_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_4_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_5_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_6_i,
  input  logic [ostp_pkg::P_W-1:0]      prob_7_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ostp_pkg::P_W-1:0]      tail_prob_o,
  output logic                          config_error_o
);
  import ostp_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] num_dists_q, rank_q;
  logic [CFG_W-1:0] n_eff;

  // stage s consumes st_valid[s]/pipe_data[s], produces index s+1
  logic        [MAX_DISTS:0] st_valid;
  logic        [MAX_DISTS:0] st_ready;
  stage_data_t               pipe_data [MAX_DISTS+1];

  prob_vec_t   raw_prob;
  stage_data_t entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dists_q <= CFG_W'(1);
      rank_q      <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NUM_DISTS: num_dists_q <= cfg_data_i;
        REG_RANK_K:    rank_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_eff = (num_dists_q > MAX_N) ? MAX_N : num_dists_q;

  assign raw_prob[0] = prob_0_i;
  assign raw_prob[1] = prob_1_i;
  assign raw_prob[2] = prob_2_i;
  assign raw_prob[3] = prob_3_i;
  assign raw_prob[4] = prob_4_i;
  assign raw_prob[5] = prob_5_i;
  assign raw_prob[6] = prob_6_i;
  assign raw_prob[7] = prob_7_i;

  // entry: count vector starts at "zero below" with certainty, probs are
  // clamped to 1.0 and zeroed past the active count
  always_comb begin
    entry      = '0;
    entry.cnt[0] = CNT_W'(ONE_FX);
    for (int i = 0; i < MAX_DISTS; i++) begin
      if (CFG_W'(i) < n_eff) begin
        entry.prob[i] = (raw_prob[i] > ONE_FX) ? ONE_FX : raw_prob[i];
      end
    end
    entry.rank = rank_q;
    entry.err  = (rank_q == '0) || (rank_q > n_eff);
  end

  assign st_valid[0]  = in_valid_i;
  assign pipe_data[0] = entry;
  assign in_ready_o   = st_ready[0];

  for (genvar s = 0; s < MAX_DISTS; s++) begin : g_stage
    ostp_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[s]),
      .in_ready_o  (st_ready[s]),
      .in_data_i   (pipe_data[s]),
      .out_valid_o (st_valid[s+1]),
      .out_ready_i (st_ready[s+1]),
      .out_data_o  (pipe_data[s+1])
    );
  end

  ostp_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (st_valid[MAX_DISTS]),
    .in_ready_o     (st_ready[MAX_DISTS]),
    .in_data_i      (pipe_data[MAX_DISTS]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tail_prob_o    (tail_prob_o),
    .config_error_o (config_error_o)
  );

  // an accepted item lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> st_valid[1])
    else $error("accepted item missing from first stage");

  // last recurrence stage holds its item while the merge is blocked
  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[MAX_DISTS] && !st_ready[MAX_DISTS]
    |=> st_valid[MAX_DISTS] && $stable(pipe_data[MAX_DISTS]))
    else $error("last stage lost or changed a stalled item");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && config_error_o |-> tail_prob_o == '0)
    else $error("nonzero tail with configuration error");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tail_prob_o <= ONE_FX)
    else $error("tail probability above 1.0");

endmodule

// File: tb/sv/order_statistic_tail_prob_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for order_statistic_tail_prob_unit: a directed vector table,
// then random phases over many register settings, each result checked against a
// typed value or an in-bench fixed-point tail model. Depends on ostp_pkg and the unit RTL.
module order_statistic_tail_prob_unit_tb;
  import ostp_pkg::*;

  // Stage depth from the unit header: 8 recurrence stages + 2 merge stages.
  localparam int PIPE_LATENCY = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int IDLE_PCT     = 32;
  localparam int PHASE_ITEMS  = 115;
  localparam int FIXED_PHASES = 12;
  localparam int NUM_PHASES   = 14;
  localparam int STEADY_PHASE = 2;   // no idling on either side
  localparam int HOLD_PHASE   = 3;   // receiver holds off, input backs up
  localparam int PAUSE_PHASE  = 5;   // sender stops mid-phase until drained

  localparam longint unsigned UNITY = 64'd1 << FRAC_BITS;
  localparam logic [P_W-1:0] P_ZERO = '0;
  localparam logic [P_W-1:0] P_ALL  = '1;

  typedef struct packed {
    logic [P_W-1:0] tail_prob;
    logic           config_error;
  } tail_res_t;

  typedef struct packed {
    logic [CFG_W-1:0] ndists;
    logic [CFG_W-1:0] rank;
    prob_vec_t        probs;
    logic             typed;    // expected result typed into the table
    tail_res_t        want;
  } vector_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  prob_vec_t            prob_d    = '0;
  logic                 out_ready = 1'b0;

  logic                 cfg_ready;
  logic                 in_ready;
  logic                 out_valid;
  logic [P_W-1:0]       tail_prob;
  logic                 config_error;

  // Register shadow, updated when a write is accepted.
  logic [CFG_W-1:0] dists_reg = CFG_W'(1);
  logic [CFG_W-1:0] rank_reg  = CFG_W'(1);

  tail_res_t   pending_tails[$];
  vector_row_t directed_rows[$];
  tail_res_t   head_result;

  int mismatches   = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  always #1 clk = ~clk;

  order_statistic_tail_prob_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .prob_0_i       (prob_d[0]),
    .prob_1_i       (prob_d[1]),
    .prob_2_i       (prob_d[2]),
    .prob_3_i       (prob_d[3]),
    .prob_4_i       (prob_d[4]),
    .prob_5_i       (prob_d[5]),
    .prob_6_i       (prob_d[6]),
    .prob_7_i       (prob_d[7]),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .tail_prob_o    (tail_prob),
    .config_error_o (config_error)
  );

  // ---------------------------------------------------------------------------
  // Tail model
  // ---------------------------------------------------------------------------

  // a*b in Q.FRAC_BITS, rounded to nearest with ties up
  function automatic longint unsigned scaled_product(input longint unsigned a,
                                                     input longint unsigned b);
    return (a * b + (UNITY >> 1)) >> FRAC_BITS;
  endfunction

  // Count distribution built one distribution at a time, then counts
  // rank..n summed and clipped at 1.0. Entries stay wide, no saturation.
  function automatic tail_res_t predict_tail(input prob_vec_t p);
    longint unsigned cnt [MAX_DISTS+1];
    longint unsigned pc;
    longint unsigned qc;
    longint unsigned acc;
    tail_res_t       res;
    int              n;
    int              i;
    int              c;
    n = (dists_reg > MAX_N) ? MAX_DISTS : int'(dists_reg);
    res.tail_prob    = '0;
    res.config_error = 1'b0;
    if (rank_reg == 0 || int'(rank_reg) > n) begin
      res.config_error = 1'b1;
      return res;
    end
    for (c = 0; c <= MAX_DISTS; c++) cnt[c] = 0;
    cnt[0] = UNITY;
    for (i = 0; i < n; i++) begin
      pc = (longint'(p[i]) > UNITY) ? UNITY : longint'(p[i]);
      qc = UNITY - pc;
      // top down so cnt[c-1] is still the old value
      for (c = i + 1; c >= 1; c--)
        cnt[c] = scaled_product(cnt[c], qc) + scaled_product(cnt[c-1], pc);
      cnt[0] = scaled_product(cnt[0], qc);
    end
    acc = 0;
    for (c = int'(rank_reg); c <= n; c++) acc += cnt[c];
    if (acc > UNITY) acc = UNITY;
    res.tail_prob = P_W'(acc);
    return res;
  endfunction

  // Mostly in range, with hard ends, values just inside the ends, and raw
  // 17-bit values (above 1.0 about half the time, clamped by the unit).
  function automatic logic [P_W-1:0] rand_prob();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return P_W'($urandom_range(0, 32'(UNITY)));
    if (sel < 80) return sel[0] ? ONE_FX : P_ZERO;
    if (sel < 90) return P_W'($urandom);
    return sel[0] ? P_W'($urandom_range(0, 16)) : ONE_FX - P_W'($urandom_range(0, 16));
  endfunction

  function automatic void add_row(input logic [CFG_W-1:0] nd, rk, input prob_vec_t p,
                                  input logic typed, input logic [P_W-1:0] tail,
                                  input logic err);
    vector_row_t r;
    r.ndists = nd;
    r.rank   = rk;
    r.probs  = p;
    r.typed  = typed;
    r.want.tail_prob    = tail;
    r.want.config_error = err;
    directed_rows.push_back(r);
  endfunction

  task automatic report_mismatch(input string field, input logic [P_W-1:0] want,
                                 input logic [P_W-1:0] got);
    mismatches++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Stop offering items and wait until every pending result has come back.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (pending_tails.size() != 0);
  endtask

  // valid stays up across back-to-back writes; closing drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                           input logic closing);
    if (!cfg_valid) cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (closing) cfg_valid <= 1'b0;
    if (idx == REG_NUM_DISTS) dists_reg = val;
    else if (idx == REG_RANK_K) rank_reg = val;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] nd, input logic [CFG_W-1:0] rk);
    drain_results();
    write_reg(REG_NUM_DISTS, nd, 1'b0);
    write_reg(REG_RANK_K, rk, 1'b1);
  endtask

  // Offer one item after a random gap; the expected result is queued at
  // the edge where the item is taken.
  task automatic send_item(input prob_vec_t p, input logic typed, input tail_res_t want);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!in_valid) in_valid <= 1'b1;
    prob_d <= p;
    do @(posedge clk); while (!in_ready);
    pending_tails.push_back(typed ? want : predict_tail(p));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, steady stretch, and requested hold-offs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Result check against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_tails.size() == 0) begin
        report_mismatch("result with nothing pending, tail_prob", '0, tail_prob);
      end else begin
        head_result = pending_tails.pop_front();
        if (tail_prob !== head_result.tail_prob)
          report_mismatch("tail_prob", head_result.tail_prob, tail_prob);
        if (config_error !== head_result.config_error)
          report_mismatch("config_error", P_W'(head_result.config_error), P_W'(config_error));
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [2*CFG_W-1:0] phase_cfg [FIXED_PHASES] = '{
    8'h11, 8'h88, 8'h81, 8'h84, 8'hF3, 8'h32,
    8'h00, 8'h57, 8'h21, 8'hFF, 8'h63, 8'h44
  };

  initial begin
    vector_row_t      row;
    prob_vec_t        p;
    logic [CFG_W-1:0] nd;
    logic [CFG_W-1:0] rk;
    int               ph;
    int               it;
    int               idx;
    int               d;
    int               lim;

    // Directed table. Rows at 1/1 run on the reset values of both registers.
    add_row(4'd1, 4'd1, {MAX_DISTS{P_ZERO}}, 1'b1, P_ZERO, 1'b0);
    add_row(4'd1, 4'd1, {MAX_DISTS{ONE_FX}}, 1'b1, ONE_FX, 1'b0);
    add_row(4'd1, 4'd1, {MAX_DISTS{P_ALL}},  1'b1, ONE_FX, 1'b0);   // clamp to 1.0
    add_row(4'd1, 4'd1, {{7{P_ALL}}, P_W'(12345)}, 1'b1, P_W'(12345), 1'b0);
    add_row(4'd8, 4'd8, {MAX_DISTS{ONE_FX}}, 1'b1, ONE_FX, 1'b0);
    add_row(4'd8, 4'd8, {MAX_DISTS{P_ALL}},  1'b1, ONE_FX, 1'b0);
    add_row(4'd8, 4'd1, {MAX_DISTS{P_ZERO}}, 1'b1, P_ZERO, 1'b0);
    add_row(4'd8, 4'd1, {P_W'(65535), P_W'(1), P_W'(40000), P_W'(32768),
                         P_W'(100), P_W'(65000), P_W'(20000), P_W'(50000)},
            1'b0, P_ZERO, 1'b0);
    add_row(4'd8, 4'd4, {MAX_DISTS{P_W'(32768)}}, 1'b0, P_ZERO, 1'b0);
    add_row(4'd8, 4'd1, {MAX_DISTS{P_W'(21845)}}, 1'b0, P_ZERO, 1'b0);  // rounding near 1.0
    add_row(4'd15, 4'd8, {MAX_DISTS{ONE_FX}}, 1'b1, ONE_FX, 1'b0);      // n capped at 8
    add_row(4'd15, 4'd9, {MAX_DISTS{ONE_FX}}, 1'b1, P_ZERO, 1'b1);      // rank past cap
    add_row(4'd0, 4'd1, {MAX_DISTS{ONE_FX}},  1'b1, P_ZERO, 1'b1);      // no distributions
    add_row(4'd3, 4'd0, {MAX_DISTS{ONE_FX}},  1'b1, P_ZERO, 1'b1);      // rank zero
    add_row(4'd3, 4'd5, {MAX_DISTS{ONE_FX}},  1'b1, P_ZERO, 1'b1);      // rank above n
    add_row(4'd5, 4'd3, {P_ALL, P_ZERO, P_W'(70000), P_W'(7),
                         P_W'(65530), P_ALL, P_W'(30000), P_W'(12000)},
            1'b0, P_ZERO, 1'b0);
    add_row(4'd2, 4'd2, {{6{P_ZERO}}, P_W'(17'h0AAAA), P_W'(17'h15555)},
            1'b0, P_ZERO, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.ndists != dists_reg || row.rank != rank_reg) set_config(row.ndists, row.rank);
      send_item(row.probs, row.typed, row.want);
    end

    // Writes to indexes other than the two registers must change nothing.
    drain_results();
    for (idx = 2; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), CFG_W'($urandom), idx == (1 << CFG_IDX_W) - 1);
    for (d = 0; d < MAX_DISTS; d++) p[d] = rand_prob();
    send_item(p, 1'b0, '0);

    // Random phases: fixed settings with the extremes, then random ones.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        {nd, rk} = phase_cfg[ph];
      end else begin
        nd  = CFG_W'($urandom_range(0, 15));
        lim = (nd > MAX_N) ? MAX_DISTS : int'(nd);
        rk  = (lim > 0 && $urandom_range(0, 99) < 80) ? CFG_W'($urandom_range(1, lim))
                                                      : CFG_W'($urandom_range(0, 15));
      end
      set_config(nd, rk);
      steady = (ph == STEADY_PHASE);
      for (it = 0; it < PHASE_ITEMS; it++) begin
        if (ph == HOLD_PHASE && it == 20) holds_asked++;
        if (ph == PAUSE_PHASE && it == 60) drain_results();
        for (d = 0; d < MAX_DISTS; d++) p[d] = rand_prob();
        send_item(p, 1'b0, '0);
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
